// File: hw/rtl/rqe_pkg.sv
`default_nettype none

package rqe_pkg;

    // fixed field widths
    localparam int SYM_W      = 8;
    localparam int CODE_W     = 64;
    localparam int POS_W      = 32;
    localparam int ALPHA_W    = 8;
    localparam int QLEN_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIX        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QGRAM_LENGTH = 2'd1;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 8'd4;
    localparam logic [QLEN_W-1:0]  QLEN_RESET  = 6'd8;

    // front queue between accept side and encoder
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             sos;
        logic             eos;
    } item_t;

    typedef struct packed {
        logic fetch_load;
        logic busy;
    } back_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/rqe_front.sv
`default_nettype none

module rqe_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  rqe_pkg::item_t       s_item,
    output logic                 q_valid,
    input  wire                  q_pop,
    output rqe_pkg::item_t       q_item
);
    import rqe_pkg::*;

    item_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    logic               push;
    logic               pop;

    assign s_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;
    assign q_item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // payload storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= s_item;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rqe_weight.sv
`default_nettype none

module rqe_weight #(
    parameter int MAX_Q = 32
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   restart,
    input  wire  [rqe_pkg::ALPHA_W-1:0]           alphabet,
    input  wire  [$clog2(MAX_Q+1)-1:0]            q_eff,
    output logic [rqe_pkg::CODE_W-1:0]            weight,
    output logic                                  busy
);
    import rqe_pkg::*;

    localparam int QW = $clog2(MAX_Q + 1);

    logic                          pending_reg;
    logic [QW-1:0]                 cnt_reg;
    logic [CODE_W-1:0]             w_reg;
    logic [CODE_W+ALPHA_W-1:0]     prod;

    assign prod   = w_reg * alphabet;
    assign weight = w_reg;
    assign busy   = pending_reg || (cnt_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b1;
            cnt_reg     <= '0;
        end else if (restart) begin
            pending_reg <= 1'b1;
        end else if (pending_reg) begin
            pending_reg <= 1'b0;
            cnt_reg     <= q_eff - 1'b1;
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // one multiply by the radix per cycle
    always_ff @(posedge aclk) begin
        if (pending_reg) begin
            w_reg <= CODE_W'(1);
        end else if (cnt_reg != '0) begin
            w_reg <= prod[CODE_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rqe_back.sv
`default_nettype none

module rqe_back #(
    parameter int MAX_Q       = 32,
    parameter int SYMBOL_BITS = 8
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   q_valid,
    input  rqe_pkg::item_t                        q_item,
    output logic                                  q_pop,
    input  wire  [rqe_pkg::ALPHA_W-1:0]           alphabet,
    input  wire  [$clog2(MAX_Q+1)-1:0]            q_eff,
    input  wire  [rqe_pkg::CODE_W-1:0]            weight,
    input  wire                                   weight_busy,
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic [rqe_pkg::CODE_W-1:0]            m_code,
    output logic [rqe_pkg::POS_W-1:0]             m_start,
    output logic                                  m_last,
    output rqe_pkg::back_status_t                 status
);
    import rqe_pkg::*;

    localparam int QW    = $clog2(MAX_Q + 1);
    localparam int AW    = (MAX_Q > 1) ? $clog2(MAX_Q) : 1;
    localparam int DEPTH = 1 << AW;

    // window memory, circular, newest at wp-1
    logic [SYMBOL_BITS-1:0] win_mem [DEPTH];
    logic [AW-1:0]          wp_reg;
    logic [AW-1:0]          rd_addr;

    // sequence bookkeeping
    logic [QW-1:0]          seen_reg;
    logic [POS_W-1:0]       pos_reg;

    // fetch stage
    logic                   f_valid_reg;
    logic [SYMBOL_BITS-1:0] f_sym_reg;
    logic                   f_sos_reg;
    logic                   f_eos_reg;
    logic                   f_roll_reg;
    logic                   f_emit_reg;
    logic [POS_W-1:0]       f_start_reg;
    logic [SYMBOL_BITS-1:0] oldest_reg;

    // multiply stage
    logic                   mul_valid_reg;
    logic [CODE_W-1:0]      t_reg;
    logic [SYMBOL_BITS-1:0] c_sym_reg;
    logic                   c_emit_reg;
    logic                   c_eos_reg;
    logic [POS_W-1:0]       c_start_reg;
    logic [CODE_W-1:0]      code_reg;

    // output register
    logic                   out_valid_reg;
    logic [CODE_W-1:0]      out_code_reg;
    logic [POS_W-1:0]       out_start_reg;
    logic                   out_last_reg;

    logic                         fetch_load;
    logic                         phase0;
    logic                         mul_done;
    logic [SYMBOL_BITS-1:0]       sym_in;
    logic [QW-1:0]                seen_eff;
    logic [QW-1:0]                seen_new;
    logic [POS_W-1:0]             pos_eff;
    logic                         grow;
    logic [QW-1:0]                q_minus1;
    logic [CODE_W-1:0]            base;
    logic [CODE_W+SYMBOL_BITS-1:0] prod1;
    logic [CODE_W-1:0]            sub;
    logic [CODE_W+ALPHA_W-1:0]    prod2;
    logic [CODE_W-1:0]            code_new;

    assign phase0     = f_valid_reg && !mul_valid_reg;
    assign fetch_load = q_valid && !weight_busy && (!f_valid_reg || phase0);
    assign mul_done   = mul_valid_reg && (!c_emit_reg || !out_valid_reg || m_ready);
    assign q_pop      = fetch_load;

    // classify the incoming symbol against the running count
    assign sym_in   = q_item.symbol[SYMBOL_BITS-1:0];
    assign seen_eff = q_item.sos ? '0 : seen_reg;
    assign pos_eff  = q_item.sos ? '0 : pos_reg;
    assign grow     = (seen_eff < q_eff);
    assign seen_new = grow ? (seen_eff + 1'b1) : seen_eff;
    assign q_minus1 = q_eff - 1'b1;
    assign rd_addr  = wp_reg - q_eff[AW-1:0];

    // subtract the leaving symbol's share
    assign base  = f_sos_reg ? '0 : code_reg;
    assign prod1 = oldest_reg * weight;
    assign sub   = f_roll_reg ? prod1[CODE_W-1:0] : '0;

    // shift in the new symbol
    assign prod2    = t_reg * alphabet;
    assign code_new = prod2[CODE_W-1:0] + CODE_W'(c_sym_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg        <= '0;
            seen_reg      <= '0;
            pos_reg       <= '0;
            f_valid_reg   <= 1'b0;
            mul_valid_reg <= 1'b0;
            code_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fetch_load) begin
                wp_reg      <= wp_reg + 1'b1;
                seen_reg    <= seen_new;
                pos_reg     <= pos_eff + 1'b1;
                f_valid_reg <= 1'b1;
            end else if (phase0) begin
                f_valid_reg <= 1'b0;
            end

            if (phase0) begin
                mul_valid_reg <= 1'b1;
            end else if (mul_done) begin
                mul_valid_reg <= 1'b0;
            end

            if (mul_done) begin
                code_reg <= code_new;
            end

            if (mul_done && c_emit_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // window memory: registered read of the oldest symbol, old data on collision
    always_ff @(posedge aclk) begin
        if (fetch_load) begin
            oldest_reg      <= win_mem[rd_addr];
            win_mem[wp_reg] <= sym_in;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (fetch_load) begin
            f_sym_reg   <= sym_in;
            f_sos_reg   <= q_item.sos;
            f_eos_reg   <= q_item.eos;
            f_roll_reg  <= !grow;
            f_emit_reg  <= (seen_new >= q_eff);
            f_start_reg <= pos_eff - POS_W'(q_minus1);
        end
        if (phase0) begin
            t_reg       <= base - sub;
            c_sym_reg   <= f_sym_reg;
            c_emit_reg  <= f_emit_reg;
            c_eos_reg   <= f_eos_reg;
            c_start_reg <= f_start_reg;
        end
        if (mul_done && c_emit_reg) begin
            out_code_reg  <= code_new;
            out_start_reg <= c_start_reg;
            out_last_reg  <= c_eos_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_code  = out_code_reg;
    assign m_start = out_start_reg;
    assign m_last  = out_last_reg;

    assign status.fetch_load = fetch_load;
    assign status.busy       = f_valid_reg || mul_valid_reg || out_valid_reg;

endmodule

`default_nettype wire

// File: hw/rtl/rolling_qgram_encoder.sv
// Rolling q-gram encoder: takes one alphabet-coded symbol per input word and
// emits the radix-A code (A = the radix register) of every q-gram of a sequence,
// modulo 2^64, together with the index of the q-gram's first symbol.
// s_tuser high starts a new sequence before its symbol; s_tlast marks the
// last symbol and comes back as m_tlast on the last q-gram. Sequences
// shorter than q give no output. Words enter a four-deep queue; the encoder
// behind it fetches the leaving symbol from a circular window memory and then
// updates the code in two steps (subtract oldest*A^(q-1), then multiply by A
// and add the symbol). A word passes the fetch, multiply-stage and output
// registers; the next word may be fetched while one is in the multiply stage,
// but its code update waits for the previous word's write of the code register.
// After reset and after every write to the radix or q-length register the
// weight A^(q-1) (q clipped to 1..MAX_Q) is rebuilt by one multiply per cycle,
// while words are queued but not encoded. There is no clearing pass at reset.
// Write configuration only while no word is in flight.

`default_nettype none

module rolling_qgram_encoder #(
    parameter int MAX_Q       = 32,
    parameter int SYMBOL_BITS = 8
) (
    input  wire                               aclk,
    input  wire                               aresetn,

    // configuration write port
    input  wire                               cfg_we,
    input  wire  [rqe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [rqe_pkg::CFG_DATA_W-1:0]    cfg_data,

    // symbol stream
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [7:0]                        s_tdata,   // [7:0] symbol
    input  wire                               s_tuser,   // [0] start_of_sequence
    input  wire                               s_tlast,   // end_of_sequence

    // q-gram code stream
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [95:0]                       m_tdata,   // [63:0] code, [95:64] qgram_start
    output logic                              m_tlast    // final_code
);
    import rqe_pkg::*;

    localparam int QW = $clog2(MAX_Q + 1);
    localparam logic [QLEN_W:0] MAXQ_EXT = (QLEN_W+1)'(MAX_Q);

    logic [ALPHA_W-1:0]  alpha_reg;
    logic [QLEN_W-1:0]   qlen_reg;
    logic [QLEN_W:0]     qlen_ext;
    logic [QLEN_W:0]     q_clip;
    logic [QW-1:0]       q_eff;
    logic                cfg_hit;

    item_t               s_item;
    item_t               q_item;
    logic                q_valid;
    logic                q_pop;

    logic [CODE_W-1:0]   weight;
    logic                weight_busy;
    logic [CODE_W-1:0]   out_code;
    logic [POS_W-1:0]    out_start;
    back_status_t        back_status;

    // configuration registers; unknown indexes are dropped
    assign cfg_hit = cfg_we && ((cfg_index == REG_RADIX) ||
                                (cfg_index == REG_QGRAM_LENGTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= ALPHA_RESET;
            qlen_reg  <= QLEN_RESET;
        end else if (cfg_we) begin
            if (cfg_index == REG_RADIX) begin
                alpha_reg <= cfg_data[ALPHA_W-1:0];
            end
            if (cfg_index == REG_QGRAM_LENGTH) begin
                qlen_reg <= cfg_data[QLEN_W-1:0];
            end
        end
    end

    // clip q into 1..MAX_Q
    assign qlen_ext = {1'b0, qlen_reg};

    always_comb begin
        priority if (qlen_ext == '0) begin
            q_clip = (QLEN_W+1)'(1);
        end else if (qlen_ext > MAXQ_EXT) begin
            q_clip = MAXQ_EXT;
        end else begin
            q_clip = qlen_ext;
        end
    end

    assign q_eff = QW'(q_clip);

    assign s_item.symbol = s_tdata;
    assign s_item.sos    = s_tuser;
    assign s_item.eos    = s_tlast;

    rqe_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item)
    );

    rqe_weight #(
        .MAX_Q (MAX_Q)
    ) u_weight (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .restart  (cfg_hit),
        .alphabet (alpha_reg),
        .q_eff    (q_eff),
        .weight   (weight),
        .busy     (weight_busy)
    );

    rqe_back #(
        .MAX_Q       (MAX_Q),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .alphabet    (alpha_reg),
        .q_eff       (q_eff),
        .weight      (weight),
        .weight_busy (weight_busy),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_code      (out_code),
        .m_start     (out_start),
        .m_last      (m_tlast),
        .status      (back_status)
    );

    assign m_tdata = {out_start, out_code};

    // a register write must hold off the encoder until the weight is rebuilt
    a_cfg_restarts_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> weight_busy)
        else $error("weight not rebuilt after register write");

    // never fetch a symbol against a stale weight
    a_no_fetch_while_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.fetch_load |-> !weight_busy)
        else $error("symbol fetched while weight busy");

    // a fetch always drains one queued word
    a_fetch_needs_word: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.fetch_load |-> q_valid)
        else $error("fetch with empty queue");

    // a waiting result word is owned by the back end
    a_result_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> back_status.busy)
        else $error("result word outside the back end");

endmodule

`default_nettype wire

// File: verif/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rqe_pkg::*;

    localparam int MAX_Q         = 32;
    localparam int SETTLE_CYCLES = 80;    // queue of four words plus a full weight rebuild
    localparam int STALL_LIMIT   = 2000;  // cycles with no word moving on either side

    // indexes past the register list
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [POS_W-1:0]  start;
        logic              is_final;
    } qgram_result_t;

    // Predictor of the rolling radix code plus the queue of q-grams still owed by the block.
    class qgram_scoreboard;
        logic [ALPHA_W-1:0] alpha;
        logic [QLEN_W-1:0]  qlen;
        logic [SYM_W-1:0]   window [MAX_Q];
        logic [5:0]         seen;
        logic [CODE_W-1:0]  code;
        logic [CODE_W-1:0]  weight;
        logic [POS_W-1:0]   pos;
        qgram_result_t      owed_q [$];
        int                 errors;

        function new();
            alpha  = ALPHA_RESET;
            qlen   = QLEN_RESET;
            errors = 0;
            clear_sequence();
            rebuild_weight();
        endfunction

        function int unsigned span();
            int unsigned q;
            q = qlen;
            if (q == 0) q = 1;
            if (q > MAX_Q) q = MAX_Q;
            return q;
        endfunction

        function void clear_sequence();
            for (int k = 0; k < MAX_Q; k++) window[k] = '0;
            seen = '0;
            code = '0;
            pos  = '0;
        endfunction

        function void rebuild_weight();
            logic [CODE_W-1:0] w;
            w = 64'd1;
            for (int unsigned k = 0; k + 1 < span(); k++) w = w * {56'd0, alpha};
            weight = w;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_RADIX:        alpha = data;
                REG_QGRAM_LENGTH: qlen  = data[QLEN_W-1:0];
                default:          return;
            endcase
            rebuild_weight();
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void note_word(logic [SYM_W-1:0] sym, logic sos, logic eos);
            int unsigned       q;
            logic [POS_W-1:0]  idx;
            qgram_result_t     r;
            q = span();
            if (sos) clear_sequence();
            if (seen < q) begin
                code = code * {56'd0, alpha} + {56'd0, sym};
                seen = seen + 6'd1;
            end else begin
                code = (code - {56'd0, window[q-1]} * weight) * {56'd0, alpha} + {56'd0, sym};
            end
            for (int k = MAX_Q - 1; k > 0; k--) window[k] = window[k-1];
            window[0] = sym;
            idx = pos;
            pos = pos + 32'd1;
            if (seen < q) return;
            r.code     = code;
            r.start    = idx - (q - 1);
            r.is_final = eos;
            owed_q.push_back(r);
        endfunction

        function void check_result(logic [CODE_W-1:0] code_got, logic [POS_W-1:0] start_got,
                                   logic final_got);
            qgram_result_t want;
            if (owed_q.size() == 0) begin
                $error("unexpected q-gram: code %h start %0d final %0b",
                       code_got, start_got, final_got);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (want.code !== code_got) begin
                $error("code: expected %h, actual %h", want.code, code_got);
                errors++;
            end
            if (want.start !== start_got) begin
                $error("qgram_start: expected %0d, actual %0d", want.start, start_got);
                errors++;
            end
            if (want.is_final !== final_got) begin
                $error("final_code: expected %0b, actual %0b", want.is_final, final_got);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports; every input starts at a known value.
    // ------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [7:0] symbol
    logic                  s_tuser   = 1'b0; // [0] start_of_sequence
    logic                  s_tlast   = 1'b0; // end_of_sequence
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [95:0]           m_tdata;          // [63:0] code, [95:64] qgram_start
    logic                  m_tlast;          // final_code

    int src_idle  = 0;   // percent of cycles the sender holds back a word
    int snk_stall = 0;   // percent of cycles the receiver drops m_tready
    int quiet     = 0;   // cycles in a row with no word moving

    qgram_scoreboard sb;

    rolling_qgram_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Receiver: redraw the stall at every falling edge, hold m_tready low during reset.
    always @(negedge aclk) begin
        m_tready = aresetn && ($urandom_range(0, 99) >= snk_stall);
    end

    // Sample both handshakes at the rising edge. Note the input word before checking the
    // output word so the predictor is always ahead; a word reaches the output only through registers.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_word(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready) sb.check_result(m_tdata[63:0], m_tdata[95:64], m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet = quiet + 1;
            end
            // Nothing has moved for far longer than any stall or rebuild can take: give up.
            if (quiet >= STALL_LIMIT) begin
                $display("rolling_qgram_encoder regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers. All of them start and end at a falling edge.
    // ------------------------------------------------------------------

    // Offer one symbol word, idling first at the current rate; drop valid once accepted.
    task automatic send_word(input logic [7:0] sym, input logic sos, input logic eos);
        begin
            while ($urandom_range(0, 99) < src_idle) begin
                s_tvalid = 1'b0;
                @(negedge aclk);
            end
            s_tvalid = 1'b1;
            s_tdata  = sym;
            s_tuser  = sos;
            s_tlast  = eos;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
    endtask

    // Write one register for a single cycle and mirror it into the predictor.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        begin
            cfg_we    = 1'b1;
            cfg_index = idx;
            cfg_data  = data;
            @(posedge aclk);
            sb.write_reg(idx, data);
            @(negedge aclk);
            cfg_we = 1'b0;
        end
    endtask

    // Hold off the sender until every owed q-gram is out, then let words that give no
    // q-gram drain from the queue before anything touches the registers.
    task automatic wait_idle();
        begin
            while (sb.pending() != 0) @(posedge aclk);
            repeat (SETTLE_CYCLES) @(posedge aclk);
            @(negedge aclk);
        end
    endtask

    task automatic set_idle(input int mode);
        begin
            case (mode)
                0: begin src_idle = 0;  snk_stall = 0;  end
                1: begin src_idle = 64; snk_stall = 0;  end
                2: begin src_idle = 0;  snk_stall = 64; end
                default: begin src_idle = 12; snk_stall = 12; end
            endcase
        end
    endtask

    // Mostly in-alphabet symbols; now and then any byte, always any byte when A is zero.
    function automatic logic [7:0] pick_symbol(input logic [7:0] a);
        if (a == 0 || $urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, a - 1));
    endfunction

    // One random phase: set the registers, then stream mostly whole sequences (start on
    // the first word, end on the last), a few short ones, a few broken flags and noise.
    task automatic run_phase(input logic [7:0] alpha_w, input logic [7:0] qlen_w,
                             input int mode, input int n_words);
        int   sent;
        int   len;
        int   q;
        logic sos;
        logic eos;
        begin
            wait_idle();
            set_idle(mode);
            cfg_write(REG_RADIX, alpha_w);
            cfg_write(REG_QGRAM_LENGTH, qlen_w);
            q    = sb.span();
            sent = 0;
            while (sent < n_words) begin
                if ($urandom_range(0, 99) < 88) begin
                    if (q > 1 && $urandom_range(0, 99) < 15) begin
                        len = $urandom_range(1, q - 1);
                    end else begin
                        len = q + $urandom_range(0, 24);
                    end
                    for (int i = 0; i < len; i++) begin
                        sos = (i == 0);
                        eos = (i == len - 1);
                        if ($urandom_range(0, 99) < 3) sos = ~sos;
                        if ($urandom_range(0, 99) < 3) eos = ~eos;
                        send_word(pick_symbol(alpha_w), sos, eos);
                    end
                    sent += len;
                end else begin
                    send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: reset settings (A = 4, q = 8). One full sequence with the byte
        // extremes, including a symbol far outside the alphabet.
        set_idle(0);
        send_word(8'd0,   1'b1, 1'b0);
        send_word(8'd3,   1'b0, 1'b0);
        send_word(8'd1,   1'b0, 1'b0);
        send_word(8'd2,   1'b0, 1'b0);
        send_word(8'd255, 1'b0, 1'b0);
        send_word(8'd0,   1'b0, 1'b0);
        send_word(8'd1,   1'b0, 1'b0);
        send_word(8'd2,   1'b0, 1'b0);
        send_word(8'd3,   1'b0, 1'b0);
        send_word(8'd3,   1'b0, 1'b1);
        // Short sequence: no q-gram at all.
        send_word(8'd0,   1'b1, 1'b0);
        send_word(8'd1,   1'b0, 1'b0);
        send_word(8'd2,   1'b0, 1'b1);
        // Keep going past the end without a new start: the sequence just continues.
        send_word(8'd3,   1'b0, 1'b0);
        send_word(8'd0,   1'b0, 1'b0);

        // q of zero acts as one; writes to unused indexes change nothing.
        wait_idle();
        cfg_write(REG_QGRAM_LENGTH, 8'd0);
        cfg_write(REG_SPARE_A, 8'hA5);
        cfg_write(REG_SPARE_B, 8'h5A);
        send_word(8'd255, 1'b0, 1'b0);
        send_word(8'd0,   1'b0, 1'b0);
        send_word(8'd1,   1'b0, 1'b1);

        // q above the window clips to MAX_Q; the code grows again until 32 symbols are in.
        wait_idle();
        cfg_write(REG_QGRAM_LENGTH, 8'hE8);
        send_word(8'd2,   1'b0, 1'b0);
        send_word(8'd3,   1'b0, 1'b1);

        // Radix zero: only the newest symbol survives in the code.
        wait_idle();
        cfg_write(REG_RADIX, 8'd0);
        cfg_write(REG_QGRAM_LENGTH, 8'd3);
        send_word(8'd5,   1'b1, 1'b0);
        send_word(8'd6,   1'b0, 1'b0);
        send_word(8'd7,   1'b0, 1'b0);
        send_word(8'd8,   1'b0, 1'b1);

        // Largest radix with q of one, start and end on the same word.
        wait_idle();
        cfg_write(REG_RADIX, 8'd255);
        cfg_write(REG_QGRAM_LENGTH, 8'd1);
        send_word(8'd200, 1'b1, 1'b1);

        // Random phases across the register extremes, cycling the idle patterns.
        run_phase(8'd4,   8'd8,   0, 80);
        run_phase(8'd1,   8'd1,   1, 80);
        run_phase(8'd255, 8'd32,  2, 80);
        run_phase(8'd2,   8'd5,   3, 80);
        run_phase(8'd0,   8'd3,   0, 80);
        run_phase(8'd255, 8'd1,   1, 80);
        run_phase(8'd1,   8'd32,  2, 80);
        run_phase(8'd20,  8'hFF,  3, 80);
        run_phase(8'd7,   8'd0,   0, 80);
        run_phase(8'd3,   8'd12,  1, 80);
        run_phase(8'd255, 8'd2,   2, 80);
        run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(0, 63)), 3, 80);

        // Drain everything still owed, then report.
        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("rolling_qgram_encoder regression: pass");
        end else begin
            $display("rolling_qgram_encoder regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
